/* rtl/tss_pkg.sv */
// Shared types, codes and fixed-point helpers of the tableau simplex solver.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tss_pkg;

  // Signed Q24.24 value held in 48 bits and its unsigned magnitude.
  typedef logic signed [47:0] qval_t;
  typedef logic [47:0]        qmag_t;

  localparam qval_t QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam qval_t QONE = 48'sh0000_0100_0000;

  // Input kinds carried on in_tuser.
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_LOAD_C = 2'd2;
  localparam logic [1:0] CMD_SOLVE  = 2'd3;

  // Result status carried on out_tuser.
  localparam logic [1:0] STAT_OPTIMAL     = 2'd0;
  localparam logic [1:0] STAT_UNBOUNDED   = 2'd1;
  localparam logic [1:0] STAT_PIVOT_LIMIT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_NUM_CONSTRAINTS = 1'b0;
  localparam logic CFG_NUM_VARS        = 1'b1;

  function automatic qmag_t q_mag(input qval_t v);
    q_mag = v[47] ? qmag_t'(-v) : qmag_t'(v);
  endfunction

  function automatic qval_t q_signed(input logic [46:0] m, input logic neg);
    q_signed = neg ? -qval_t'({1'b0, m}) : qval_t'({1'b0, m});
  endfunction

  // Saturated value for a result whose magnitude overflowed.
  function automatic qval_t q_sat(input logic neg);
    q_sat = neg ? -QMAX : QMAX;
  endfunction

  // t - p, saturated to the symmetric 48-bit range.
  function automatic qval_t q_sub_sat(input qval_t t, input qval_t p);
    logic signed [48:0] d;
    d = {t[47], t} - {p[47], p};
    if (d > 49'sh0_7FFF_FFFF_FFFF) q_sub_sat = QMAX;
    else if (d < -49'sh0_7FFF_FFFF_FFFF) q_sub_sat = -QMAX;
    else q_sub_sat = d[47:0];
  endfunction

  // Q24.24 to Q16.16: drop 8 bits toward zero, then saturate to 32 bits.
  function automatic logic [31:0] to_q16(input qval_t v);
    qmag_t       mg;
    logic [39:0] m;
    logic [39:0] negm;
    mg   = q_mag(v);
    m    = mg[47:8];
    negm = ~m + 40'd1;
    if (v[47]) to_q16 = (m > 40'h00_8000_0000) ? 32'h8000_0000 : negm[31:0];
    else       to_q16 = (m > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/tableau_simplex_solver.sv */
// Tableau simplex solver: maximize c.x subject to A x <= b, x >= 0.
// Depends on tss_pkg, tss_div and tss_mul.
//
// Usage. Items arrive on the in_ stream: in_tuser is the command (load A,
// load b, load c or solve), in_tdata carries row index, column index and a
// Q16.16 coefficient. A load transfer is taken every idle cycle and writes
// one entry of the coefficient memory. A solve transfer drops in_tready until
// the last result has been transferred; it builds the slack tableau in the
// tableau memory and pivots there. The cfg_ port sets the number of
// constraints and variables and must only be written while no solve runs.
// Results leave on the out_ stream: out_tdata holds variable index, value
// and objective, out_tuser the status, out_tlast marks the final result.
// Steps. A solve builds the tableau, scans the objective row for the
// entering column, tests the ratio of each row with a positive entry there
// with the bit-serial divider, divides each entry of the pivot row by the
// pivot and updates every other row with the multiplier for each pivot,
// then collects the solution row by row. After reset the coefficient
// memory is swept to zero with in_tready low, one entry per cycle, over
// all MAX_CONSTRAINTS*MAX_VARS+MAX_CONSTRAINTS+MAX_VARS entries. A stalled
// receiver holds the current result; nothing is dropped.
`default_nettype none

module tableau_simplex_solver #(
  parameter int MAX_CONSTRAINTS = 16,
  parameter int MAX_VARS        = 16,
  parameter int MAX_PIVOTS      = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream. tdata: row_index[3:0], col_index[7:4], coef_value[39:8].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,
  // tuser: cmd[1:0].
  input  wire logic [1:0]  in_tuser,
  // Result stream. tdata: var_index[3:0], var_value[35:4],
  // objective_value[67:36], zero fill [71:68].
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,
  // tuser: status[1:0].
  output logic [1:0]       out_tuser,
  output logic             out_tlast,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import tss_pkg::*;

  localparam int TROWS  = MAX_CONSTRAINTS + 1;
  localparam int TCOLS  = MAX_VARS + MAX_CONSTRAINTS + 1;
  localparam int TDEPTH = TROWS * TCOLS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int CDEPTH = MAX_CONSTRAINTS * MAX_VARS + MAX_CONSTRAINTS + MAX_VARS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int B_BASE = MAX_CONSTRAINTS * MAX_VARS;
  localparam int C_BASE = MAX_CONSTRAINTS * MAX_VARS + MAX_CONSTRAINTS;
  localparam int RW     = $clog2(MAX_CONSTRAINTS + 1);
  localparam int NW     = $clog2(MAX_VARS + 1);
  localparam int CW     = $clog2(MAX_VARS + MAX_CONSTRAINTS + 1);
  localparam int PW     = $clog2(MAX_PIVOTS + 1);
  localparam int RIW    = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int XW     = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_BLD_RD  = 5'd2;
  localparam logic [4:0] S_BLD_WR  = 5'd3;
  localparam logic [4:0] S_COL_RD  = 5'd4;
  localparam logic [4:0] S_COL_CHK = 5'd5;
  localparam logic [4:0] S_ROW_RD  = 5'd6;
  localparam logic [4:0] S_ROW_CHK = 5'd7;
  localparam logic [4:0] S_ROW_RHS = 5'd8;
  localparam logic [4:0] S_ROW_DIV = 5'd9;
  localparam logic [4:0] S_PV_RD   = 5'd10;
  localparam logic [4:0] S_PV_LAT  = 5'd11;
  localparam logic [4:0] S_NRM_RD  = 5'd12;
  localparam logic [4:0] S_NRM_ST  = 5'd13;
  localparam logic [4:0] S_NRM_WT  = 5'd14;
  localparam logic [4:0] S_EL_F_RD = 5'd15;
  localparam logic [4:0] S_EL_F_LT = 5'd16;
  localparam logic [4:0] S_EL_P_RD = 5'd17;
  localparam logic [4:0] S_EL_T_RD = 5'd18;
  localparam logic [4:0] S_EL_T_LT = 5'd19;
  localparam logic [4:0] S_EL_WT   = 5'd20;
  localparam logic [4:0] S_XO_RD   = 5'd21;
  localparam logic [4:0] S_XO_LAT  = 5'd22;
  localparam logic [4:0] S_X_RD    = 5'd23;
  localparam logic [4:0] S_X_LAT   = 5'd24;
  localparam logic [4:0] S_EM_LOAD = 5'd25;
  localparam logic [4:0] S_EMIT    = 5'd26;

  // Memories: coefficient store (Q16.16) and the working tableau (Q24.24).
  logic [31:0] coef_mem [CDEPTH];
  qval_t       tab_mem  [TDEPTH];

  logic [4:0]     state_r;
  logic [CAW-1:0] clr_r;
  logic [RW-1:0]  m_r;
  logic [NW-1:0]  n_r;
  logic [RW-1:0]  row_r;
  logic [CW-1:0]  col_r;
  logic [RW-1:0]  pr_r;
  logic [CW-1:0]  pc_r;
  logic           found_r;
  qval_t          best_r;
  qval_t          dvs_r;
  qval_t          pv_r;
  qval_t          f_r;
  qval_t          t_r;
  logic [PW-1:0]  pcount_r;
  logic [CW-1:0]  basis_r [MAX_CONSTRAINTS];
  logic [31:0]    xq_r    [MAX_VARS];
  logic [31:0]    obj_r;
  logic [31:0]    coef_rdata_r;
  qval_t          tab_rdata_r;

  logic           out_valid_r;
  logic [3:0]     out_idx_r;
  logic [31:0]    out_val_r;
  logic [31:0]    out_obj_r;
  logic [1:0]     out_stat_r;
  logic           out_last_r;

  // Decoded input item.
  logic [1:0]  in_cmd;
  logic [3:0]  in_row;
  logic [3:0]  in_col;
  logic [31:0] in_coef;
  logic        in_xfer;
  logic        row_ok;
  logic        col_ok;

  assign in_cmd  = in_tuser;
  assign in_row  = in_tdata[3:0];
  assign in_col  = in_tdata[7:4];
  assign in_coef = in_tdata[39:8];
  assign in_xfer = in_tvalid && in_tready;
  assign row_ok  = {3'b000, in_row} < 7'(MAX_CONSTRAINTS);
  assign col_ok  = {3'b000, in_col} < 7'(MAX_VARS);

  // Configuration values are clamped into 1..MAX.
  logic [4:0]    cfg_v;
  logic [RW-1:0] cfg_m;
  logic [NW-1:0] cfg_n;

  assign cfg_v = (cfg_data == 5'd0) ? 5'd1 : cfg_data;
  assign cfg_m = ({2'b00, cfg_v} > 7'(MAX_CONSTRAINTS)) ? RW'(MAX_CONSTRAINTS) : RW'(cfg_v);
  assign cfg_n = ({2'b00, cfg_v} > 7'(MAX_VARS)) ? NW'(MAX_VARS) : NW'(cfg_v);

  logic [CW-1:0] rhs;
  logic [CW-1:0] n_ext;
  logic          row_lt_m;
  logic          col_lt_n;
  logic          row_last;

  assign n_ext    = CW'(n_r);
  assign rhs      = n_ext + CW'(m_r);
  assign row_lt_m = row_r < m_r;
  assign col_lt_n = col_r < n_ext;
  assign row_last = row_r == (m_r - RW'(1));

  // Coefficient memory ports.
  logic           coef_we;
  logic [CAW-1:0] coef_waddr;
  logic [31:0]    coef_wdata;
  logic [CAW-1:0] coef_raddr;

  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = clr_r;
    coef_wdata = '0;
    if (state_r == S_CLEAR) begin
      coef_we = 1'b1;
    end else if (in_xfer) begin
      coef_wdata = in_coef;
      unique case (in_cmd)
        CMD_LOAD_A: begin
          coef_we    = row_ok && col_ok;
          coef_waddr = CAW'(in_row) * CAW'(MAX_VARS) + CAW'(in_col);
        end
        CMD_LOAD_B: begin
          coef_we    = row_ok;
          coef_waddr = CAW'(B_BASE) + CAW'(in_row);
        end
        CMD_LOAD_C: begin
          coef_we    = col_ok;
          coef_waddr = CAW'(C_BASE) + CAW'(in_col);
        end
        default: coef_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (!row_lt_m) coef_raddr = CAW'(C_BASE) + CAW'(col_r);
    else if (col_lt_n) coef_raddr = CAW'(row_r) * CAW'(MAX_VARS) + CAW'(col_r);
    else coef_raddr = CAW'(B_BASE) + CAW'(row_r);
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
    coef_rdata_r <= coef_mem[coef_raddr];
  end

  // Tableau build value for entry (row, col).
  qval_t coef_q;
  qval_t bld_val;

  assign coef_q = {{8{coef_rdata_r[31]}}, coef_rdata_r, 8'h00};

  always_comb begin
    if (row_lt_m) begin
      if (col_lt_n || col_r == rhs) bld_val = coef_q;
      else if (col_r == n_ext + CW'(row_r)) bld_val = QONE;
      else bld_val = '0;
    end else begin
      bld_val = col_lt_n ? -coef_q : '0;
    end
  end

  // Arithmetic units.
  logic  div_start;
  qval_t div_q;
  logic  div_done;
  logic  mul_start;
  qval_t mul_p;
  logic  mul_done;

  assign div_start = (state_r == S_ROW_RHS) || (state_r == S_NRM_ST);
  assign mul_start = state_r == S_EL_T_RD;

  tss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tab_rdata_r),
    .divisor  ((state_r == S_NRM_ST) ? pv_r : dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  tss_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (f_r),
    .op_b    (tab_rdata_r),
    .done    (mul_done),
    .product (mul_p)
  );

  // Tableau memory ports: one read, one write.
  logic [RW-1:0]  rd_row;
  logic [CW-1:0]  rd_col;
  logic [RW-1:0]  wr_row;
  logic           tab_we;
  qval_t          tab_wdata;
  logic [TAW-1:0] tab_raddr;
  logic [TAW-1:0] tab_waddr;

  always_comb begin
    rd_row = row_r;
    rd_col = col_r;
    unique case (state_r)
      S_COL_RD:  rd_row = m_r;
      S_ROW_RD:  rd_col = pc_r;
      S_ROW_CHK: rd_col = rhs;
      S_PV_RD: begin
        rd_row = pr_r;
        rd_col = pc_r;
      end
      S_NRM_RD:  rd_row = pr_r;
      S_EL_F_RD: rd_col = pc_r;
      S_EL_P_RD: rd_row = pr_r;
      S_XO_RD: begin
        rd_row = m_r;
        rd_col = rhs;
      end
      S_X_RD:    rd_col = rhs;
      default:   rd_row = row_r;
    endcase
  end

  always_comb begin
    tab_we    = 1'b0;
    wr_row    = row_r;
    tab_wdata = bld_val;
    unique case (state_r)
      S_BLD_WR: tab_we = 1'b1;
      S_NRM_WT: begin
        tab_we    = div_done;
        wr_row    = pr_r;
        tab_wdata = div_q;
      end
      S_EL_WT: begin
        tab_we    = mul_done;
        tab_wdata = q_sub_sat(t_r, mul_p);
      end
      default: tab_we = 1'b0;
    endcase
  end

  assign tab_raddr = TAW'(rd_row) * TAW'(TCOLS) + TAW'(rd_col);
  assign tab_waddr = TAW'(wr_row) * TAW'(TCOLS) + TAW'(col_r);

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rdata_r <= tab_mem[tab_raddr];
  end

  // Ratio test bookkeeping. A row is finished either when its pivot-column
  // entry is not positive or when its ratio comes back from the divider.
  logic rd_pos;
  logic row_hit;
  logic found_now;
  logic row_advance;

  assign rd_pos      = !tab_rdata_r[47] && (tab_rdata_r != '0);
  assign row_hit     = (state_r == S_ROW_DIV) && div_done && (!found_r || div_q < best_r);
  assign found_now   = found_r || row_hit;
  assign row_advance = ((state_r == S_ROW_CHK) && !rd_pos) ||
                       ((state_r == S_ROW_DIV) && div_done);

  logic [CW-1:0] basis_row;
  assign basis_row = basis_r[row_r[RIW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      m_r         <= RW'(1);
      n_r         <= NW'(1);
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      pcount_r    <= '0;
      for (int k = 0; k < MAX_CONSTRAINTS; k++) basis_r[k] <= CW'(k + 1);
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_NUM_CONSTRAINTS) m_r <= cfg_m;
        else n_r <= cfg_n;
      end

      if (row_hit) begin
        best_r <= div_q;
        pr_r   <= row_r;
      end
      if (row_advance) begin
        found_r <= found_now;
        if (!row_last) begin
          row_r   <= row_r + RW'(1);
          state_r <= S_ROW_RD;
        end else if (!found_now || pcount_r == PW'(MAX_PIVOTS)) begin
          // No leaving row, or the pivot budget is spent: one status result.
          out_valid_r <= 1'b1;
          out_idx_r   <= '0;
          out_val_r   <= '0;
          out_obj_r   <= '0;
          out_stat_r  <= found_now ? STAT_PIVOT_LIMIT : STAT_UNBOUNDED;
          out_last_r  <= 1'b1;
          state_r     <= S_EMIT;
        end else begin
          pcount_r <= pcount_r + PW'(1);
          state_r  <= S_PV_RD;
        end
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CAW'(1);
          if (clr_r == CAW'(CDEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer && in_cmd == CMD_SOLVE) begin
            row_r   <= '0;
            col_r   <= '0;
            state_r <= S_BLD_RD;
          end
        end
        S_BLD_RD: state_r <= S_BLD_WR;
        S_BLD_WR: begin
          if (row_lt_m && col_r == '0) basis_r[row_r[RIW-1:0]] <= n_ext + CW'(row_r);
          if (col_r == rhs) begin
            col_r <= '0;
            if (row_lt_m) begin
              row_r   <= row_r + RW'(1);
              state_r <= S_BLD_RD;
            end else begin
              pcount_r <= '0;
              state_r  <= S_COL_RD;
            end
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= S_BLD_RD;
          end
        end
        S_COL_RD: state_r <= S_COL_CHK;
        S_COL_CHK: begin
          // Entering column: the first one with a negative objective entry.
          if (tab_rdata_r[47]) begin
            pc_r    <= col_r;
            row_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_ROW_RD;
          end else if (col_r == rhs - CW'(1)) begin
            state_r <= S_XO_RD;
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= S_COL_RD;
          end
        end
        S_ROW_RD: state_r <= S_ROW_CHK;
        S_ROW_CHK: begin
          if (rd_pos) begin
            dvs_r   <= tab_rdata_r;
            state_r <= S_ROW_RHS;
          end
        end
        S_ROW_RHS: state_r <= S_ROW_DIV;
        S_ROW_DIV: begin
          // The ratio test bookkeeping above leaves this state once the
          // divider is done.
        end
        S_PV_RD:   state_r <= S_PV_LAT;
        S_PV_LAT: begin
          pv_r    <= tab_rdata_r;
          col_r   <= '0;
          state_r <= S_NRM_RD;
        end
        S_NRM_RD: state_r <= S_NRM_ST;
        S_NRM_ST: state_r <= S_NRM_WT;
        S_NRM_WT: begin
          if (div_done) begin
            if (col_r == rhs) begin
              row_r   <= '0;
              state_r <= S_EL_F_RD;
            end else begin
              col_r   <= col_r + CW'(1);
              state_r <= S_NRM_RD;
            end
          end
        end
        S_EL_F_RD: begin
          if (row_r == pr_r) begin
            if (row_lt_m) begin
              row_r <= row_r + RW'(1);
            end else begin
              basis_r[pr_r[RIW-1:0]] <= pc_r;
              col_r   <= '0;
              state_r <= S_COL_RD;
            end
          end else begin
            state_r <= S_EL_F_LT;
          end
        end
        S_EL_F_LT: begin
          f_r     <= tab_rdata_r;
          col_r   <= '0;
          state_r <= S_EL_P_RD;
        end
        S_EL_P_RD: state_r <= S_EL_T_RD;
        S_EL_T_RD: state_r <= S_EL_T_LT;
        S_EL_T_LT: begin
          t_r     <= tab_rdata_r;
          state_r <= S_EL_WT;
        end
        S_EL_WT: begin
          if (mul_done) begin
            if (col_r != rhs) begin
              col_r   <= col_r + CW'(1);
              state_r <= S_EL_P_RD;
            end else if (row_lt_m) begin
              row_r   <= row_r + RW'(1);
              state_r <= S_EL_F_RD;
            end else begin
              basis_r[pr_r[RIW-1:0]] <= pc_r;
              col_r   <= '0;
              state_r <= S_COL_RD;
            end
          end
        end
        S_XO_RD: state_r <= S_XO_LAT;
        S_XO_LAT: begin
          obj_r <= to_q16(tab_rdata_r);
          for (int k = 0; k < MAX_VARS; k++) xq_r[k] <= '0;
          row_r   <= '0;
          state_r <= S_X_RD;
        end
        S_X_RD: state_r <= S_X_LAT;
        S_X_LAT: begin
          if (basis_row < n_ext) xq_r[basis_row[XW-1:0]] <= to_q16(tab_rdata_r);
          if (row_last) begin
            col_r   <= '0;
            state_r <= S_EM_LOAD;
          end else begin
            row_r   <= row_r + RW'(1);
            state_r <= S_X_RD;
          end
        end
        S_EM_LOAD: begin
          out_valid_r <= 1'b1;
          out_idx_r   <= col_r[3:0];
          out_val_r   <= xq_r[col_r[XW-1:0]];
          out_obj_r   <= obj_r;
          out_stat_r  <= STAT_OPTIMAL;
          out_last_r  <= col_r == (n_ext - CW'(1));
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              col_r   <= col_r + CW'(1);
              state_r <= S_EM_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_obj_r, out_val_r, out_idx_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* rtl/tss_div.sv */
// Bit-serial restoring divider for Q24.24 quotients with a positive divisor.
// Depends on tss_pkg; one quotient bit per cycle.
`default_nettype none

module tss_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  tss_pkg::qval_t     dividend,
  input  tss_pkg::qval_t     divisor,
  output logic               done,
  output tss_pkg::qval_t     quotient
);
  import tss_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [48:0] rem_r;
  logic [71:0] num_r;
  logic [47:0] dvs_r;
  logic        neg_r;

  logic [48:0] rem_sh;
  logic [49:0] diff;
  logic        ge;

  assign rem_sh = {rem_r[47:0], num_r[71]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge     = ~diff[49];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd72;
        rem_r  <= '0;
        num_r  <= {q_mag(dividend), 24'h00_0000};
        dvs_r  <= divisor;
        neg_r  <= dividend[47];
      end else if (busy_r) begin
        rem_r <= ge ? diff[48:0] : rem_sh;
        num_r <= {num_r[70:0], ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // A quotient of 2^47 or more no longer fits the signed range.
  assign quotient = (|num_r[71:47]) ? q_sat(neg_r) : q_signed(num_r[46:0], neg_r);
  assign done     = done_r;

endmodule

`default_nettype wire

/* rtl/tss_mul.sv */
// Multi-cycle Q24.24 multiplier built from four 24x24 partial products.
// Depends on tss_pkg; product is truncated toward zero and saturated.
`default_nettype none

module tss_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  tss_pkg::qval_t     op_a,
  input  tss_pkg::qval_t     op_b,
  output logic               done,
  output tss_pkg::qval_t     product
);
  import tss_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [2:0]  step_r;
  logic        ppv_r;
  logic [1:0]  ppk_r;
  logic [47:0] pp_r;
  logic [95:0] acc_r;
  qmag_t       ma_r;
  qmag_t       mb_r;
  logic        neg_r;

  logic [23:0] x_sel;
  logic [23:0] y_sel;
  logic [95:0] pp_shift;

  assign x_sel = step_r[1] ? ma_r[47:24] : ma_r[23:0];
  assign y_sel = step_r[0] ? mb_r[47:24] : mb_r[23:0];

  always_comb begin
    unique case ({1'b0, ppk_r[1]} + {1'b0, ppk_r[0]})
      2'd0:    pp_shift = {48'h0, pp_r};
      2'd1:    pp_shift = {24'h0, pp_r, 24'h0};
      default: pp_shift = {pp_r, 48'h0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ppv_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
        ppv_r  <= 1'b0;
        acc_r  <= '0;
        ma_r   <= q_mag(op_a);
        mb_r   <= q_mag(op_b);
        neg_r  <= op_a[47] ^ op_b[47];
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          pp_r   <= x_sel * y_sel;
          ppk_r  <= step_r[1:0];
          ppv_r  <= 1'b1;
          step_r <= step_r + 3'd1;
        end else begin
          ppv_r <= 1'b0;
        end
        if (ppv_r) begin
          acc_r <= acc_r + pp_shift;
          if (ppk_r == 2'd3) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign product = (|acc_r[95:71]) ? q_sat(neg_r) : q_signed(acc_r[70:24], neg_r);
  assign done    = done_r;

endmodule

`default_nettype wire

/* rtl/tss_check.sv */
// Port-level assertions for the tableau simplex solver, bound to its top.
// Depends on tss_pkg for the command and status codes.
`default_nettype none

module tss_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);
  import tss_pkg::*;

  // Reset leaves the block in its clearing sweep with no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

  // Inputs are never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // A solve transfer stalls the input side.
  a_solve_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_SOLVE |=> !in_tready)
    else $error("input still ready after a solve");

  // Unbounded and pivot-limit results are single, final and all zero.
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OPTIMAL |-> out_tlast && out_tdata == 72'd0)
    else $error("malformed status result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind tableau_simplex_solver tss_check u_tss_check (.*);

`default_nettype wire

/* tb/tableau_simplex_solver_test.sv */
// Self-checking testbench for the tableau simplex solver.
// It depends on tss_pkg and the tableau_simplex_solver RTL only.
`default_nettype none

module tableau_simplex_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tss_pkg::*;

  localparam int NROW = 16;
  localparam int NCOL = 16;
  localparam int PIVOT_CAP = 256;
  localparam longint QTOP = 64'sh7FFF_FFFF_FFFF;
  localparam longint UNIT = 64'sh100_0000;
  localparam int CYCLE_LIMIT = 50_000_000;
  localparam int ITEM_TARGET = 170;

  // One result of a solve, split into its fields.
  typedef struct packed {
    logic [3:0]  var_idx;
    logic [31:0] var_val;
    logic [31:0] obj_val;
    logic [1:0]  status;
    logic        last;
  } solution_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  tableau_simplex_solver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the block: the coefficient store, the working tableau, the
  // basis and the two size registers.
  int     coef_a [NROW][NCOL];
  int     coef_b [NROW];
  int     coef_c [NCOL];
  longint tab [NROW+1][NCOL+NROW+1];
  int     basis [NROW];
  int     rows_used;
  int     cols_used;

  solution_t pending_solutions[$];
  int        error_count;
  int        items_sent;
  int        burst_left;
  longint    cycle_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The run is cut off at a generous limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the solver, Q24.24 in a 48-bit range.
  // ---------------------------------------------------------------------------
  function automatic longint clip48(input longint v);
    if (v > QTOP) return QTOP;
    if (v < -QTOP) return -QTOP;
    return v;
  endfunction

  function automatic longint unsigned abs_of(input longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint with_sign(input longint unsigned m, input bit neg);
    longint r;
    r = (m > QTOP) ? QTOP : longint'(m);
    return neg ? -r : r;
  endfunction

  // Product truncated toward zero; the partial products keep it exact.
  function automatic longint fx_mul(input longint a, input longint b);
    longint unsigned ma, mb, ah, al, bh, bl, hh, s;
    bit neg;
    ma = abs_of(a);
    mb = abs_of(b);
    ah = ma >> 24;
    al = ma & 64'hFF_FFFF;
    bh = mb >> 24;
    bl = mb & 64'hFF_FFFF;
    neg = (a < 0) != (b < 0);
    hh = ah * bh;
    if (hh >= (64'd1 << 24)) return neg ? -QTOP : QTOP;
    s = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
    return with_sign(s, neg);
  endfunction

  // Quotient by a positive divisor, truncated toward zero.
  function automatic longint fx_div(input longint a, input longint d);
    longint unsigned ma, md, q, r, frac;
    ma = abs_of(a);
    md = d;
    q = ma / md;
    r = ma % md;
    frac = 0;
    if (q >= (64'd1 << 23)) return (a < 0) ? -QTOP : QTOP;
    for (int k = 0; k < 24; k++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= md) begin
        r = r - md;
        frac = frac | 1;
      end
    end
    return with_sign((q << 24) | frac, a < 0);
  endfunction

  function automatic logic [31:0] narrow_q16(input longint v);
    longint unsigned m;
    m = abs_of(v) >> 8;
    if (v < 0) return (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(m));
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(m);
  endfunction

  function automatic solution_t status_only(input logic [1:0] st);
    solution_t s;
    s = '0;
    s.status = st;
    s.last = 1'b1;
    return s;
  endfunction

  // Builds the slack tableau, pivots to the end and queues the results.
  function automatic void predict_solution();
    int rhs, pc, pr, pivots;
    longint best, ratio, pv, f;
    longint xval [NCOL];
    solution_t s;
    rhs = cols_used + rows_used;
    for (int i = 0; i <= NROW; i++)
      for (int j = 0; j <= NCOL + NROW; j++) tab[i][j] = 0;
    for (int i = 0; i < rows_used; i++) begin
      for (int j = 0; j < cols_used; j++) tab[i][j] = longint'(coef_a[i][j]) * 256;
      tab[i][cols_used + i] = UNIT;
      tab[i][rhs] = longint'(coef_b[i]) * 256;
      basis[i] = cols_used + i;
    end
    for (int j = 0; j < cols_used; j++) tab[rows_used][j] = -(longint'(coef_c[j]) * 256);
    pivots = 0;
    forever begin
      pc = rhs;
      pr = rows_used;
      best = 0;
      for (int j = 0; j < rhs; j++)
        if (tab[rows_used][j] < 0) begin
          pc = j;
          break;
        end
      if (pc == rhs) break;
      for (int i = 0; i < rows_used; i++)
        if (tab[i][pc] > 0) begin
          ratio = fx_div(tab[i][rhs], tab[i][pc]);
          if (pr == rows_used || ratio < best) begin
            best = ratio;
            pr = i;
          end
        end
      if (pr == rows_used) begin
        pending_solutions.push_back(status_only(STAT_UNBOUNDED));
        return;
      end
      if (pivots >= PIVOT_CAP) begin
        pending_solutions.push_back(status_only(STAT_PIVOT_LIMIT));
        return;
      end
      pivots++;
      pv = tab[pr][pc];
      for (int j = 0; j <= rhs; j++) tab[pr][j] = fx_div(tab[pr][j], pv);
      for (int i = 0; i <= rows_used; i++) begin
        if (i == pr) continue;
        f = tab[i][pc];
        for (int j = 0; j <= rhs; j++) tab[i][j] = clip48(tab[i][j] - fx_mul(f, tab[pr][j]));
      end
      basis[pr] = pc;
    end
    for (int j = 0; j < NCOL; j++) xval[j] = 0;
    for (int i = 0; i < rows_used; i++)
      if (basis[i] < cols_used) xval[basis[i]] = tab[i][rhs];
    for (int j = 0; j < cols_used; j++) begin
      s.var_idx = 4'(j);
      s.var_val = narrow_q16(xval[j]);
      s.obj_val = narrow_q16(tab[rows_used][rhs]);
      s.status = STAT_OPTIMAL;
      s.last = (j + 1 == cols_used);
      pending_solutions.push_back(s);
    end
  endfunction

  // Applies one accepted transfer to the shadow state.
  function automatic void absorb_item(input logic [1:0] cmd, input logic [3:0] row,
                                      input logic [3:0] col, input logic [31:0] val);
    case (cmd)
      CMD_LOAD_A: coef_a[row][col] = int'(val);
      CMD_LOAD_B: coef_b[row] = int'(val);
      CMD_LOAD_C: coef_c[col] = int'(val);
      default: predict_solution();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. The sender works in bursts separated by random gaps; each
  // accepted transfer is folded into the shadow state right at its edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] cmd, input logic [3:0] row,
                           input logic [3:0] col, input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {val, col, row};
    do @(posedge clk); while (!in_tready);
    absorb_item(cmd, row, col, val);
    items_sent++;
  endtask

  task automatic solve_now();
    send_item(CMD_SOLVE, 4'($urandom), 4'($urandom), $urandom);
  endtask

  // Waits until every predicted result has been transferred and lets the
  // block settle before its registers are touched.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] data);
    int v;
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    v = (data == 0) ? 1 : int'(data);
    if (idx == CFG_NUM_CONSTRAINTS) rows_used = (v > NROW) ? NROW : v;
    else cols_used = (v > NCOL) ? NCOL : v;
  endtask

  // The receiver switches between three stall patterns in turn: always ready,
  // coin flips, or a periodic stall.
  int stall_phase;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase >> 6) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom);
      default: out_tready <= (stall_phase % 5) != 0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checking. Every result transfer is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch in %s: expected %h, actual %h", $realtime, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    solution_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_solutions.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $realtime, out_tdata);
        error_count++;
      end else begin
        want = pending_solutions.pop_front();
        compare_field("var_index", want.var_idx, out_tdata[3:0]);
        compare_field("var_value", want.var_val, out_tdata[35:4]);
        compare_field("objective_value", want.obj_val, out_tdata[67:36]);
        compare_field("status", want.status, out_tuser);
        compare_field("last", want.last, out_tlast);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // After reset the store is all zero and the problem is one by one.
  task automatic test_reset_problem();
    solve_now();
  endtask

  // A textbook problem: maximize 3x + 5y with x <= 4, 2y <= 12, 3x + 2y <= 18.
  task automatic test_textbook();
    drain_results();
    write_reg(CFG_NUM_CONSTRAINTS, 5'd3);
    write_reg(CFG_NUM_VARS, 5'd2);
    send_item(CMD_LOAD_A, 4'd0, 4'd0, 32'h0001_0000);
    send_item(CMD_LOAD_A, 4'd1, 4'd1, 32'h0002_0000);
    send_item(CMD_LOAD_A, 4'd2, 4'd0, 32'h0003_0000);
    send_item(CMD_LOAD_A, 4'd2, 4'd1, 32'h0002_0000);
    send_item(CMD_LOAD_B, 4'd0, 4'd0, 32'h0004_0000);
    send_item(CMD_LOAD_B, 4'd1, 4'd0, 32'h000C_0000);
    send_item(CMD_LOAD_B, 4'd2, 4'd0, 32'h0012_0000);
    send_item(CMD_LOAD_C, 4'd0, 4'd0, 32'h0003_0000);
    send_item(CMD_LOAD_C, 4'd0, 4'd1, 32'h0005_0000);
    solve_now();
  endtask

  // A column with a profit but no positive entry makes the problem unbounded.
  task automatic test_unbounded();
    drain_results();
    write_reg(CFG_NUM_CONSTRAINTS, 5'd0);
    send_item(CMD_LOAD_A, 4'd0, 4'd0, 32'hFFFF_0000);
    solve_now();
  endtask

  // Extreme coefficients drive the output conversion into saturation, and the
  // most negative profit leaves the start point optimal.
  task automatic test_extremes();
    drain_results();
    write_reg(CFG_NUM_VARS, 5'd31);
    write_reg(CFG_NUM_VARS, 5'd1);
    send_item(CMD_LOAD_A, 4'd0, 4'd0, 32'h0000_0001);
    send_item(CMD_LOAD_B, 4'd0, 4'd15, 32'h7FFF_FFFF);
    send_item(CMD_LOAD_C, 4'd15, 4'd0, 32'h7FFF_FFFF);
    solve_now();
    send_item(CMD_LOAD_C, 4'd0, 4'd0, 32'h8000_0000);
    solve_now();
  endtask

  function automatic logic [31:0] random_coef();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1, 2, 3: return -32'($urandom_range(0, 32'h0002_0000));
      default: return $urandom_range(0, 32'h0005_0000);
    endcase
  endfunction

  // Random problems: sizes mostly small, one at full size, each loaded with
  // random content and solved; some stray loads are mixed in as noise.
  task automatic test_random_problems();
    int m, n;
    bit full_done;
    full_done = 0;
    while (items_sent < ITEM_TARGET || !full_done) begin
      drain_results();
      if (!full_done && items_sent > ITEM_TARGET / 2) begin
        m = 16;
        n = 16;
        full_done = 1;
      end else begin
        m = $urandom_range(1, 4);
        n = $urandom_range(1, 4);
      end
      write_reg(CFG_NUM_CONSTRAINTS, 5'(m));
      write_reg(CFG_NUM_VARS, 5'(n));
      for (int i = 0; i < m; i++)
        for (int j = 0; j < n; j++)
          if (m == 16 ? (i == j || $urandom_range(0, 7) == 0) : $urandom_range(0, 3) != 0)
            send_item(CMD_LOAD_A, 4'(i), 4'(j), random_coef());
      for (int i = 0; i < m; i++)
        send_item(CMD_LOAD_B, 4'(i), 4'($urandom), $urandom_range(0, 32'h0032_0000));
      for (int j = 0; j < n; j++)
        send_item(CMD_LOAD_C, 4'($urandom), 4'(j),
                  $urandom_range(0, 32'h000A_0000) - 32'h0002_0000);
      repeat ($urandom_range(0, 2))
        send_item(2'($urandom_range(0, 2)), 4'($urandom), 4'($urandom), $urandom);
      solve_now();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_LOAD_A;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_CONSTRAINTS;
    cfg_data = '0;
    out_tready = 1'b0;
    stall_phase = 0;
    cycle_count = 0;
    error_count = 0;
    items_sent = 0;
    burst_left = 0;
    rows_used = 1;
    cols_used = 1;
    for (int i = 0; i < NROW; i++) begin
      coef_b[i] = 0;
      for (int j = 0; j < NCOL; j++) coef_a[i][j] = 0;
    end
    for (int j = 0; j < NCOL; j++) coef_c[j] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_problem();
    test_textbook();
    test_unbounded();
    test_extremes();
    test_random_problems();

    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/tss_pkg.sv
rtl/tss_div.sv
rtl/tss_mul.sv
rtl/tableau_simplex_solver.sv
rtl/tss_check.sv
tb/tableau_simplex_solver_test.sv
